>>> rtl/lcdns_pkg.sv
package lcdns_pkg;

  // Request opcodes (in_tuser)
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_HOME   = 3'd4;
  localparam logic [2:0] OP_CURSOR = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
  localparam logic [1:0] CFG_SETTLE       = 2'd1;

  localparam logic [7:0] ENABLE_PULSE_RST = 8'd1;
  localparam logic [7:0] SETTLE_RST       = 8'd5;

  // Fixed command bytes
  localparam logic [7:0] BYTE_CLEAR    = 8'h01;
  localparam logic [7:0] BYTE_HOME     = 8'h02;
  localparam logic [7:0] BASE_ROW1     = 8'h80;
  localparam logic [7:0] BASE_ROW2     = 8'hC0;

  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_TWO = 2'd2;

  // Byte counts and pin-state phases
  localparam logic [2:0] INIT_LEN    = 3'd7;
  localparam logic [2:0] PHASE_SETUP_HI = 3'd0;
  localparam logic [2:0] PHASE_EN_HI    = 3'd1;
  localparam logic [2:0] PHASE_SETUP_LO = 3'd2;
  localparam logic [2:0] PHASE_EN_LO    = 3'd3;
  localparam logic [2:0] PHASE_SETTLE   = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic       load;      // latch request fields
    logic       emit;      // load the output register with one pin state
    logic [2:0] byte_idx;  // byte within the request
    logic [2:0] phase;     // pin state within the byte
    logic       last;      // final pin state of the request
  } lcdns_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req_bytes; // bytes the offered request expands to
  } lcdns_status_t;

  // Power-up command sequence
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h02;
      3'd4:    b = 8'h0C;
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/lcdns_ctrl.sv
module lcdns_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  lcdns_pkg::lcdns_status_t status,
  output lcdns_pkg::lcdns_cmd_t    cmd
);
  import lcdns_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] nbytes_r, nbytes_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic accept;
  logic emit;
  logic last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign emit       = (state_r == S_RUN) && (!out_valid_r || out_tready);
  assign last       = (phase_r == PHASE_SETTLE) && (byte_idx_r == nbytes_r - 3'd1);

  assign cmd.load     = accept;
  assign cmd.emit     = emit;
  assign cmd.byte_idx = byte_idx_r;
  assign cmd.phase    = phase_r;
  assign cmd.last     = last;

  // Next-state logic: walk phases, then bytes
  always_comb begin
    state_nxt     = state_r;
    byte_idx_nxt  = byte_idx_r;
    phase_nxt     = phase_r;
    nbytes_nxt    = nbytes_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept && (status.req_bytes != 3'd0)) begin
          state_nxt    = S_RUN;
          byte_idx_nxt = 3'd0;
          phase_nxt    = PHASE_SETUP_HI;
          nbytes_nxt   = status.req_bytes;
        end
      end
      S_RUN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          if (phase_r == PHASE_SETTLE) begin
            phase_nxt = PHASE_SETUP_HI;
            if (last) begin
              state_nxt = S_IDLE;
            end else begin
              byte_idx_nxt = byte_idx_r + 3'd1;
            end
          end else begin
            phase_nxt = phase_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      byte_idx_r  <= 3'd0;
      phase_r     <= PHASE_SETUP_HI;
      nbytes_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_idx_r  <= byte_idx_nxt;
      phase_r     <= phase_nxt;
      nbytes_r    <= nbytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (byte_idx_r < nbytes_r) && (phase_r <= PHASE_SETTLE))
    else $error("byte index or phase out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("final pin state did not end the request");

  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status.req_bytes == 3'd0)) |=> (state_r == S_IDLE))
    else $error("request without pin states left idle");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && !out_valid_r |=> !out_valid_r)
    else $error("pin state produced while idle");

endmodule

>>> rtl/lcdns_dp.sv
module lcdns_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             in_tuser,
  input  logic [23:0]            in_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  lcdns_pkg::lcdns_cmd_t    cmd,
  output lcdns_pkg::lcdns_status_t status,
  output logic [15:0]            out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);
  import lcdns_pkg::*;

  logic [7:0] enable_pulse_r;
  logic [7:0] settle_r;

  logic [2:0] op_r;
  logic [7:0] data_r;
  logic [7:0] col_r;
  logic [1:0] row_r;

  logic       rs_out_r;
  logic       en_out_r;
  logic [3:0] nib_out_r;
  logic [7:0] hold_out_r;
  logic       last_out_r;

  logic [1:0] in_row;
  logic [7:0] cur_byte;
  logic [7:0] row_base;
  logic [3:0] nib;
  logic       en;
  logic [7:0] hold;

  assign in_row = in_tdata[17:16];

  // Bytes per offered request
  always_comb begin
    case (in_tuser)
      OP_INIT:   status.req_bytes = INIT_LEN;
      OP_CMD,
      OP_CHAR,
      OP_CLEAR,
      OP_HOME:   status.req_bytes = 3'd1;
      OP_CURSOR: status.req_bytes = ((in_row == ROW_ONE) || (in_row == ROW_TWO)) ?
                                    3'd1 : 3'd0;
      default:   status.req_bytes = 3'd0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r <= ENABLE_PULSE_RST;
      settle_r       <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE_PULSE: enable_pulse_r <= cfg_wdata;
        CFG_SETTLE:       settle_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      data_r <= in_tdata[7:0];
      col_r  <= in_tdata[15:8];
      row_r  <= in_row;
    end
  end

  // Byte being sent
  assign row_base = (row_r == ROW_ONE) ? BASE_ROW1 : BASE_ROW2;

  always_comb begin
    case (op_r)
      OP_INIT:   cur_byte = init_byte(cmd.byte_idx);
      OP_CMD,
      OP_CHAR:   cur_byte = data_r;
      OP_CLEAR:  cur_byte = BYTE_CLEAR;
      OP_HOME:   cur_byte = BYTE_HOME;
      OP_CURSOR: cur_byte = row_base + col_r - 8'd1;
      default:   cur_byte = 8'h00;
    endcase
  end

  // Pin state for the current phase
  always_comb begin
    case (cmd.phase)
      PHASE_SETUP_HI: begin nib = cur_byte[7:4]; en = 1'b0; hold = 8'd0;           end
      PHASE_EN_HI:    begin nib = cur_byte[7:4]; en = 1'b1; hold = enable_pulse_r; end
      PHASE_SETUP_LO: begin nib = cur_byte[3:0]; en = 1'b0; hold = 8'd0;           end
      PHASE_EN_LO:    begin nib = cur_byte[3:0]; en = 1'b1; hold = enable_pulse_r; end
      PHASE_SETTLE:   begin nib = cur_byte[3:0]; en = 1'b0; hold = settle_r;       end
      default:        begin nib = 4'h0;          en = 1'b0; hold = 8'd0;           end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rs_out_r   <= (op_r == OP_CHAR);
      en_out_r   <= en;
      nib_out_r  <= nib;
      hold_out_r <= hold;
      last_out_r <= cmd.last;
    end
  end

  assign out_tdata = {3'b000, hold_out_r, nib_out_r, en_out_r};
  assign out_tlast = last_out_r;
  assign out_tuser = rs_out_r;

endmodule

>>> rtl/char_lcd_nibble_sequencer.sv
// Write-only sequencer for a character LCD on a 4-bit bus. Each request is
// expanded to command or character bytes and every byte to five pin states
// (set-up high nibble, enable high nibble, set-up low nibble, enable low
// nibble, settle), each with the time in ms to hold it. Pin states come one
// per cycle from the phase counter while the output is not stalled. A new
// request is taken only once the previous one has been fully expanded; a
// request that yields nothing (bad opcode, cursor row other than 1 or 2)
// is dropped without leaving idle. Write enable_pulse_ms and settle_ms
// only while idle.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte, [15:8] column, [17:16] row, [23:18] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: [2:0] opcode
  input  logic [2:0]  in_tuser,
  // out_tdata: [0] enable, [4:1] data_nibble, [12:5] hold_ms, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // out_tuser: [0] reg_select
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import lcdns_pkg::*;

  lcdns_cmd_t    cmd;
  lcdns_status_t status;

  lcdns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lcdns_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule
